// ===== rtl/core/lfpd_pkg.sv =====
// Shared types and constants of the PD line follower drive block.
package lfpd_pkg;

    localparam int SENSOR_N   = 8;
    localparam int WEIGHT_W   = 7;
    localparam int DUTY_W     = 12;
    localparam int GAIN_W     = 8;
    localparam int ALPHA_W    = 9;
    localparam int SMOOTH_W   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIV_STEPS   = 7;
    localparam int DIV_CNT_W   = 3;
    localparam int QUO_W       = 7;
    localparam int REM_W       = 3;
    localparam int CNT_W       = 4;

    localparam logic signed [WEIGHT_W-1:0] CHAN_WEIGHT [SENSOR_N] = '{
        7'sd40, 7'sd30, 7'sd15, 7'sd3, -7'sd3, -7'sd15, -7'sd30, -7'sd40
    };

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 8'd10;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 8'd20;
    localparam logic [GAIN_W-1:0]  DEAD_BAND_RST    = 8'd3;
    localparam logic [DUTY_W-1:0]  BASE_DUTY_RST    = 12'd1100;
    localparam logic [DUTY_W-1:0]  DUTY_FLOOR_RST   = 12'd300;
    localparam logic [DUTY_W-1:0]  DUTY_CEILING_RST = 12'd3500;
    localparam logic [ALPHA_W-1:0] SMOOTH_ALPHA_RST = 9'd77;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_DEAD_BAND    = 3'd2,
        REG_BASE_DUTY    = 3'd3,
        REG_DUTY_FLOOR   = 3'd4,
        REG_DUTY_CEILING = 3'd5,
        REG_SMOOTH_ALPHA = 3'd6
    } lfpd_reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_XLOAD,
        ST_FIRST,
        ST_EMA_OLD,
        ST_EMA_NEW,
        ST_EMA_ADD,
        ST_EMA_UPD,
        ST_PD_PROP,
        ST_PD_DERIV,
        ST_PD_ADD,
        ST_PD_TRUNC,
        ST_DEAD,
        ST_OUT
    } lfpd_state_t;

    typedef enum logic [1:0] {
        MUL_EMA_OLD,
        MUL_EMA_NEW,
        MUL_PD_PROP,
        MUL_PD_DERIV
    } lfpd_mul_sel_t;

    typedef struct packed {
        logic          capture;
        logic          div_step;
        logic          x_load;
        logic          first_load;
        lfpd_mul_sel_t mul_sel;
        logic          prod_load;
        logic          acc_load;
        logic          acc_add;
        logic          ema_update;
        logic          corr_load;
        logic          dead_apply;
        logic          out_load;
    } lfpd_cmd_t;

    typedef struct packed {
        logic first;
        logic out_free;
    } lfpd_status_t;

endpackage

// ===== rtl/core/lfpd_ctrl.sv =====
// Sequencer of the PD line follower drive: steps the datapath through one word.
module lfpd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lfpd_pkg::lfpd_status_t status,
    output lfpd_pkg::lfpd_cmd_t    cmd
);
    import lfpd_pkg::*;

    lfpd_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_XLOAD;
                end
            end
            ST_XLOAD:    state_next = status.first ? ST_FIRST : ST_EMA_OLD;
            ST_FIRST:    state_next = ST_PD_PROP;
            ST_EMA_OLD:  state_next = ST_EMA_NEW;
            ST_EMA_NEW:  state_next = ST_EMA_ADD;
            ST_EMA_ADD:  state_next = ST_EMA_UPD;
            ST_EMA_UPD:  state_next = ST_PD_PROP;
            ST_PD_PROP:  state_next = ST_PD_DERIV;
            ST_PD_DERIV: state_next = ST_PD_ADD;
            ST_PD_ADD:   state_next = ST_PD_TRUNC;
            ST_PD_TRUNC: state_next = ST_DEAD;
            ST_DEAD:     state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.mul_sel = MUL_EMA_OLD;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DIV:      cmd.div_step   = 1'b1;
            ST_XLOAD:    cmd.x_load     = 1'b1;
            ST_FIRST:    cmd.first_load = 1'b1;
            ST_EMA_OLD: begin
                cmd.mul_sel   = MUL_EMA_OLD;
                cmd.prod_load = 1'b1;
            end
            ST_EMA_NEW: begin
                cmd.mul_sel   = MUL_EMA_NEW;
                cmd.prod_load = 1'b1;
                cmd.acc_load  = 1'b1;
            end
            ST_EMA_ADD:  cmd.acc_add    = 1'b1;
            ST_EMA_UPD:  cmd.ema_update = 1'b1;
            ST_PD_PROP: begin
                cmd.mul_sel   = MUL_PD_PROP;
                cmd.prod_load = 1'b1;
            end
            ST_PD_DERIV: begin
                cmd.mul_sel   = MUL_PD_DERIV;
                cmd.prod_load = 1'b1;
                cmd.acc_load  = 1'b1;
            end
            ST_PD_ADD:   cmd.acc_add    = 1'b1;
            ST_PD_TRUNC: cmd.corr_load  = 1'b1;
            ST_DEAD:     cmd.dead_apply = 1'b1;
            ST_OUT:      cmd.out_load   = status.out_free;
            default:     cmd.capture    = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/lfpd_dp.sv =====
// Datapath of the PD line follower drive: divider, shared multiplier, filter and clamp.
module lfpd_dp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lfpd_pkg::lfpd_cmd_t                 cmd,
    output lfpd_pkg::lfpd_status_t              status,
    input  logic [7:0]                          s_tdata,
    input  logic                                cfg_we,
    input  logic [lfpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata
);
    import lfpd_pkg::*;

    localparam int XW = WEIGHT_W + FRAC_BITS;
    localparam int MA = (XW > SMOOTH_W + 1) ? XW : SMOOTH_W + 1;
    localparam int MB = ALPHA_W + 1;
    localparam int PW = MA + MB;
    localparam int AW = PW + 1;
    localparam int DW = AW + 1;

    // configuration
    logic [GAIN_W-1:0]  prop_gain_reg, prop_gain_next;
    logic [GAIN_W-1:0]  deriv_gain_reg, deriv_gain_next;
    logic [GAIN_W-1:0]  dead_band_reg, dead_band_next;
    logic [DUTY_W-1:0]  base_duty_reg, base_duty_next;
    logic [DUTY_W-1:0]  duty_floor_reg, duty_floor_next;
    logic [DUTY_W-1:0]  duty_ceiling_reg, duty_ceiling_next;
    logic [ALPHA_W-1:0] smooth_alpha_reg, smooth_alpha_next;

    // filter state
    logic signed [SMOOTH_W-1:0] smoothed_reg, smoothed_next;
    logic signed [SMOOTH_W-1:0] prev_reg, prev_next;
    logic                       first_reg, first_next;

    // working registers
    logic               sign_reg, sign_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   divisor_reg, divisor_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] corr_reg, corr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [23:0]          out_data_reg, out_data_next;

    // combinational
    logic signed [7:0]      sum_v;
    logic [CNT_W-1:0]       cnt_v;
    logic [REM_W:0]         trial;
    logic [WEIGHT_W-1:0]    raw_v;
    logic [ALPHA_W-1:0]     alpha_eff;
    logic signed [SMOOTH_W:0] diff_v;
    logic signed [MA-1:0]   mul_a;
    logic signed [MB-1:0]   mul_b;
    logic signed [AW-1:0]   ema_q;
    logic signed [AW-1:0]   pd_q;
    logic [AW-1:0]          corr_mag;
    logic signed [DW-1:0]   base_s;
    logic [DUTY_W-1:0]      left_v;
    logic [DUTY_W-1:0]      right_v;

    function automatic logic signed [SMOOTH_W-1:0] sat16(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'(17'sd32767);
        lo = AW'(-17'sd32768);
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[SMOOTH_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DW-1:0] v,
                                                     input logic [DUTY_W-1:0] lo,
                                                     input logic [DUTY_W-1:0] hi);
        logic signed [DW-1:0] r;
        logic signed [DW-1:0] lo_s;
        logic signed [DW-1:0] hi_s;
        lo_s = $signed({{(DW-DUTY_W){1'b0}}, lo});
        hi_s = $signed({{(DW-DUTY_W){1'b0}}, hi});
        r = v;
        if (r < lo_s) begin
            r = lo_s;
        end
        if (r > hi_s) begin
            r = hi_s;
        end
        return r[DUTY_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg    <= PROP_GAIN_RST;
            deriv_gain_reg   <= DERIV_GAIN_RST;
            dead_band_reg    <= DEAD_BAND_RST;
            base_duty_reg    <= BASE_DUTY_RST;
            duty_floor_reg   <= DUTY_FLOOR_RST;
            duty_ceiling_reg <= DUTY_CEILING_RST;
            smooth_alpha_reg <= SMOOTH_ALPHA_RST;
            smoothed_reg     <= '0;
            prev_reg         <= '0;
            first_reg        <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            prop_gain_reg    <= prop_gain_next;
            deriv_gain_reg   <= deriv_gain_next;
            dead_band_reg    <= dead_band_next;
            base_duty_reg    <= base_duty_next;
            duty_floor_reg   <= duty_floor_next;
            duty_ceiling_reg <= duty_ceiling_next;
            smooth_alpha_reg <= smooth_alpha_next;
            smoothed_reg     <= smoothed_next;
            prev_reg         <= prev_next;
            first_reg        <= first_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sign_reg     <= sign_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        corr_reg     <= corr_next;
        out_data_reg <= out_data_next;
    end

    // configuration writes
    always_comb begin
        prop_gain_next    = prop_gain_reg;
        deriv_gain_next   = deriv_gain_reg;
        dead_band_next    = dead_band_reg;
        base_duty_next    = base_duty_reg;
        duty_floor_next   = duty_floor_reg;
        duty_ceiling_next = duty_ceiling_reg;
        smooth_alpha_next = smooth_alpha_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:    prop_gain_next    = cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:   deriv_gain_next   = cfg_wdata[GAIN_W-1:0];
                REG_DEAD_BAND:    dead_band_next    = cfg_wdata[GAIN_W-1:0];
                REG_BASE_DUTY:    base_duty_next    = cfg_wdata[DUTY_W-1:0];
                REG_DUTY_FLOOR:   duty_floor_next   = cfg_wdata[DUTY_W-1:0];
                REG_DUTY_CEILING: duty_ceiling_next = cfg_wdata[DUTY_W-1:0];
                REG_SMOOTH_ALPHA: smooth_alpha_next = cfg_wdata[ALPHA_W-1:0];
                default:          prop_gain_next    = prop_gain_reg;
            endcase
        end
    end

    // weighted sum and count of on-line sensors
    always_comb begin
        sum_v = '0;
        cnt_v = '0;
        for (int i = 0; i < SENSOR_N; i++) begin
            if (!s_tdata[i]) begin
                sum_v = sum_v + 8'(CHAN_WEIGHT[i]);
                cnt_v = cnt_v + 1'b1;
            end
        end
    end

    always_comb begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        raw_v     = sign_reg ? (WEIGHT_W'(0) - quo_reg) : quo_reg;
        alpha_eff = (smooth_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : smooth_alpha_reg;
        diff_v    = (SMOOTH_W+1)'(smoothed_reg) - (SMOOTH_W+1)'(prev_reg);
        case (cmd.mul_sel)
            MUL_EMA_OLD: begin
                mul_a = MA'(smoothed_reg);
                mul_b = $signed({1'b0, ALPHA_ONE - alpha_eff});
            end
            MUL_EMA_NEW: begin
                mul_a = MA'(x_reg);
                mul_b = $signed({1'b0, alpha_eff});
            end
            MUL_PD_PROP: begin
                mul_a = MA'(smoothed_reg);
                mul_b = $signed({{(MB-GAIN_W){1'b0}}, prop_gain_reg});
            end
            MUL_PD_DERIV: begin
                mul_a = MA'(diff_v);
                mul_b = $signed({{(MB-GAIN_W){1'b0}}, deriv_gain_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        // truncation toward zero of the scaled sums
        ema_q = acc_reg[AW-1] ? ((acc_reg + AW'(255)) >>> 8) : (acc_reg >>> 8);
        pd_q  = acc_reg[AW-1]
              ? ((acc_reg + AW'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS)
              : (acc_reg >>> FRAC_BITS);
        corr_mag = corr_reg[AW-1] ? AW'(-corr_reg) : AW'(corr_reg);
        base_s   = $signed({{(DW-DUTY_W){1'b0}}, base_duty_reg});
        left_v   = clamp_duty(base_s - DW'(corr_reg), duty_floor_reg, duty_ceiling_reg);
        right_v  = clamp_duty(base_s + DW'(corr_reg), duty_floor_reg, duty_ceiling_reg);
    end

    always_comb begin
        sign_next      = sign_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        corr_next      = corr_reg;
        smoothed_next  = smoothed_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.capture) begin
            sign_next    = sum_v[7];
            quo_next     = sum_v[7] ? QUO_W'(-sum_v) : QUO_W'(sum_v);
            rem_next     = '0;
            // no sensor on the line: sum is zero, any divisor gives zero
            divisor_next = (cnt_v == '0) ? CNT_W'(1) : cnt_v;
        end
        if (cmd.div_step) begin
            if (trial >= divisor_reg) begin
                rem_next = REM_W'(trial - divisor_reg);
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[REM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.x_load) begin
            x_next = {raw_v, {FRAC_BITS{1'b0}}};
        end
        if (cmd.first_load) begin
            smoothed_next = sat16(AW'(x_reg));
            first_next    = 1'b0;
        end
        if (cmd.prod_load) begin
            prod_next = mul_a * mul_b;
        end
        if (cmd.acc_load) begin
            acc_next = AW'(prod_reg);
        end
        if (cmd.acc_add) begin
            acc_next = acc_reg + AW'(prod_reg);
        end
        if (cmd.ema_update) begin
            smoothed_next = sat16(ema_q);
        end
        if (cmd.corr_load) begin
            corr_next = pd_q;
            prev_next = smoothed_reg;
        end
        if (cmd.dead_apply) begin
            if (corr_mag < AW'(dead_band_reg)) begin
                corr_next = '0;
            end
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {right_v, left_v};
        end
    end

    assign status.first    = first_reg;
    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

// ===== rtl/core/line_follow_pd_drive.sv =====
// Top level of the PD line follower with differential wheel drive.
//
// s_ channel: one word per sensor sample, s_tdata[7:0] = sensor bits,
// a 0 bit marks a sensor that sees the line.
// m_ channel: one word per sample, left and right wheel duties.
// cfg_we/cfg_index/cfg_wdata write the gain, deadband, duty and filter
// registers; write only while no sample is in flight.
// Each word passes the seven-step sensor divider, the filter update
// (skipped for the first sample after reset) and the PD step, with one
// multiplier shared by filter and PD; a new sample is taken only once the
// previous word has been loaded into the output register.
// Reset clears the filter state, returns registers to defaults and drops
// m_tvalid. A finished word waits in the output register while the next
// sample is taken and computed; the block holds that next word until the
// register frees, and s_tready stays low meanwhile.
module line_follow_pd_drive #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] sensor_bits
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [11:0] left_drive, [23:12] right_drive
    input  logic                             cfg_we,
    input  logic [lfpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lfpd_pkg::*;

    lfpd_cmd_t    cmd;
    lfpd_status_t status;

    lfpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lfpd_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sim/lfpd_drive_checker.sv =====
// Checker for the PD drive block: mirrors the registers, predicts each drive word and compares.
module lfpd_drive_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] sensor_bits
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [23:0]                      m_tdata,   // [11:0] left_drive, [23:12] right_drive
    input  logic                             cfg_we,
    input  logic [lfpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               fail_count,
    output int                               duty_pending,
    output int                               duty_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfpd_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0] right;
        logic [DUTY_W-1:0] left;
    } duty_pair_t;

    logic [GAIN_W-1:0]  kp, kd, dead;
    logic [DUTY_W-1:0]  base, duty_lo, duty_hi;
    logic [ALPHA_W-1:0] alpha;
    int                 ema, ema_prev;   // Q(FRAC_BITS), held within 16 bit range
    bit                 fresh;
    int                 fails = 0;
    int                 checked = 0;
    duty_pair_t         duty_queue[$];

    function automatic longint trunc_shift(longint v, int sh);
        if (v < 0) begin
            return -((-v) >>> sh);
        end
        return v >>> sh;
    endfunction

    function automatic int sat16(longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return int'(v);
    endfunction

    function automatic longint clamp_duty(longint v);
        if (v < longint'(duty_lo)) begin
            v = longint'(duty_lo);
        end
        if (v > longint'(duty_hi)) begin
            v = longint'(duty_hi);
        end
        return v;
    endfunction

    // line position: mean weight of the sensors on the line, zero for none or all
    function automatic int line_error(logic [7:0] bits);
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < SENSOR_N; i++) begin
            if (!bits[i]) begin
                sum += int'(CHAN_WEIGHT[i]);
                cnt++;
            end
        end
        if (cnt == 0 || cnt == SENSOR_N) begin
            return 0;
        end
        return sum / cnt;
    endfunction

    function automatic duty_pair_t next_duties(logic [7:0] bits);
        longint     x, a, pd, corr, mag, lft, rgt;
        duty_pair_t d;
        x = longint'(line_error(bits)) * (longint'(1) << FRAC_BITS);
        a = (alpha > ALPHA_ONE) ? 256 : longint'(alpha);
        if (fresh) begin
            ema   = sat16(x);
            fresh = 1'b0;
        end else begin
            ema = sat16(trunc_shift(longint'(ema) * (256 - a) + x * a, 8));
        end
        pd       = longint'(kp) * ema + longint'(kd) * (longint'(ema) - ema_prev);
        ema_prev = ema;
        corr     = trunc_shift(pd, FRAC_BITS);
        mag      = (corr < 0) ? -corr : corr;
        if (mag < longint'(dead)) begin
            corr = 0;
        end
        lft     = clamp_duty(longint'(base) - corr);
        rgt     = clamp_duty(longint'(base) + corr);
        d.left  = lft[DUTY_W-1:0];
        d.right = rgt[DUTY_W-1:0];
        return d;
    endfunction

    always @(posedge aclk) begin
        duty_pair_t got, want;
        if (!aresetn) begin
            kp       = PROP_GAIN_RST;
            kd       = DERIV_GAIN_RST;
            dead     = DEAD_BAND_RST;
            base     = BASE_DUTY_RST;
            duty_lo  = DUTY_FLOOR_RST;
            duty_hi  = DUTY_CEILING_RST;
            alpha    = SMOOTH_ALPHA_RST;
            ema      = 0;
            ema_prev = 0;
            fresh    = 1'b1;
            duty_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PROP_GAIN:    kp      = cfg_wdata[GAIN_W-1:0];
                    REG_DERIV_GAIN:   kd      = cfg_wdata[GAIN_W-1:0];
                    REG_DEAD_BAND:    dead    = cfg_wdata[GAIN_W-1:0];
                    REG_BASE_DUTY:    base    = cfg_wdata[DUTY_W-1:0];
                    REG_DUTY_FLOOR:   duty_lo = cfg_wdata[DUTY_W-1:0];
                    REG_DUTY_CEILING: duty_hi = cfg_wdata[DUTY_W-1:0];
                    REG_SMOOTH_ALPHA: alpha   = cfg_wdata[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (duty_queue.size() == 0) begin
                    $error("drive word with no sensor word pending: left %0d right %0d",
                           got.left, got.right);
                    fails++;
                end else begin
                    want = duty_queue.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_drive: expected %0d, got %0d", want.left, got.left);
                        fails++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_drive: expected %0d, got %0d", want.right, got.right);
                        fails++;
                    end
                    checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                duty_queue.push_back(next_duties(s_tdata));
            end
        end
        fail_count   <= fails;
        duty_pending <= duty_queue.size();
        duty_checked <= checked;
    end

endmodule

// ===== sim/line_follow_pd_drive_test.sv =====
// Testbench top for the PD drive block: sensor words, register settings, back-pressure and verdict.
module line_follow_pd_drive_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lfpd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 175;
    localparam int FRAC_BITS   = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [GAIN_W-1:0]  kp, kd, dead;
        logic [DUTY_W-1:0]  base, duty_lo, duty_hi;
        logic [ALPHA_W-1:0] alpha;
    } drive_cfg_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'hFF;   // [7:0] sensor_bits
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;             // [11:0] left_drive, [23:12] right_drive
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count, duty_pending, duty_checked;
    int words_sent = 0;
    int cycles     = 0;
    int line_pos   = 3;
    bit quiet      = 1'b0;

    line_follow_pd_drive #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lfpd_drive_checker #(.FRAC_BITS(FRAC_BITS)) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .duty_pending (duty_pending),
        .duty_checked (duty_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit, %0d drive words still due", duty_pending);
            $display("Verification failed");
            $finish;
        end
    end

    // drive word sink: per word either always ready or a stall once the word shows
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_word(input logic [7:0] bits);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (duty_pending != 0);
    endtask

    initial begin
        drive_cfg_t  c;
        logic [11:0] junk;
        logic [7:0]  bits;
        int          width;
        int          pick;
        logic [7:0]  directed[$];

        // off-centre first word, none and all on the line, each sensor alone, mixes
        directed = '{
            8'hFE, 8'hFF, 8'h00, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
            8'h7E, 8'hFC, 8'h3F, 8'hE7, 8'hF8, 8'h1F, 8'h55, 8'hAA, 8'h01, 8'h80
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults first
        foreach (directed[i]) begin
            send_word(directed[i]);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();

            c.kp      = GAIN_W'($urandom);
            c.kd      = GAIN_W'($urandom);
            c.dead    = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
                                                    : GAIN_W'($urandom_range(0, 12));
            c.base    = DUTY_W'($urandom_range(200, 3900));
            c.duty_lo = DUTY_W'($urandom_range(0, 1200));
            c.duty_hi = DUTY_W'($urandom_range(2400, 4095));
            pick      = $urandom_range(0, 9);
            if (pick == 0) begin
                c.alpha = ALPHA_W'($urandom_range(257, 511));
            end else if (pick == 1) begin
                c.alpha = '0;
            end else begin
                c.alpha = ALPHA_W'($urandom_range(1, 256));
            end

            case (p)
                0: begin
                    c.kp      = 8'd255;
                    c.kd      = 8'd255;
                    c.dead    = 8'd0;
                    c.duty_lo = 12'd0;
                    c.duty_hi = 12'd4095;
                    c.alpha   = ALPHA_ONE;
                end
                1: begin
                    c.alpha = 9'd0;   // filter holds
                    c.dead  = 8'd0;
                end
                2: begin
                    c.alpha   = 9'd511;
                    c.duty_lo = 12'd3000;   // floor above ceiling
                    c.duty_hi = 12'd1000;
                end
                3: begin
                    c.kp      = 8'd0;
                    c.kd      = 8'd0;
                    c.dead    = 8'd255;
                    c.base    = 12'd0;
                    c.duty_lo = 12'd0;
                    c.duty_hi = 12'd0;
                    c.alpha   = 9'd1;
                end
                4: begin
                    c.base    = 12'd4095;
                    c.duty_lo = 12'd4095;
                    c.duty_hi = 12'd4095;
                end
                5: begin
                    c.kp      = 8'd255;
                    c.kd      = 8'd255;
                    c.dead    = 8'd255;
                    c.base    = 12'd4095;
                    c.duty_lo = 12'd0;
                    c.duty_hi = 12'd4095;
                    c.alpha   = 9'd257;
                end
                default: ;
            endcase

            // unused bits of the narrow registers carry noise, then a write to the spare index
            cfg_we    <= 1'b1;
            junk = 12'($urandom);
            cfg_index <= REG_PROP_GAIN;
            cfg_wdata <= {junk[11:8], c.kp};
            @(posedge aclk);
            junk = 12'($urandom);
            cfg_index <= REG_DERIV_GAIN;
            cfg_wdata <= {junk[11:8], c.kd};
            @(posedge aclk);
            junk = 12'($urandom);
            cfg_index <= REG_DEAD_BAND;
            cfg_wdata <= {junk[11:8], c.dead};
            @(posedge aclk);
            cfg_index <= REG_BASE_DUTY;
            cfg_wdata <= c.base;
            @(posedge aclk);
            cfg_index <= REG_DUTY_FLOOR;
            cfg_wdata <= c.duty_lo;
            @(posedge aclk);
            cfg_index <= REG_DUTY_CEILING;
            cfg_wdata <= c.duty_hi;
            @(posedge aclk);
            junk = 12'($urandom);
            cfg_index <= REG_SMOOTH_ALPHA;
            cfg_wdata <= {junk[11:9], c.alpha};
            @(posedge aclk);
            junk = 12'($urandom);
            cfg_index <= REG_UNUSED;
            cfg_wdata <= junk;
            @(posedge aclk);
            cfg_we    <= 1'b0;

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 32 == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    bits = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
                end else if (pick < 25) begin
                    bits = 8'($urandom);
                end else begin
                    // line drifting slowly under the sensor bar
                    line_pos += int'($urandom_range(0, 2)) - 1;
                    if (line_pos < 0) begin
                        line_pos = 0;
                    end
                    if (line_pos > 7) begin
                        line_pos = 7;
                    end
                    width = $urandom_range(1, 3);
                    bits  = 8'hFF;
                    for (int i = 0; i < width; i++) begin
                        if (line_pos + i < 8) begin
                            bits[line_pos + i] = 1'b0;
                        end
                    end
                end
                send_word(bits);
            end
        end

        wait_drained();
        repeat (30) @(posedge aclk);

        $display("Sent %0d sensor words across reset defaults and %0d register settings,",
                 words_sent, PHASES);
        $display("with filter hold, overweighted alpha, floor above ceiling; %0d checked",
                 duty_checked);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
